FILE: src/kshi_pkg.sv
// ----------------------------------------------------------------------------
// kshi_pkg
// Types and codes shared by the K-line slow init handshake block.
// ----------------------------------------------------------------------------
package kshi_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h55;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_RX_BYTE  = 2'd1,
		OP_TICK     = 2'd2,
		OP_SYNC_DUR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_ADDR = 2'd0,
		ACT_TX   = 2'd1,
		ACT_BAUD = 2'd2,
		ACT_DONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TIMEOUT = 3'd1,
		ST_SYNC    = 3'd2,
		ST_ECHO    = 3'd3,
		ST_KEYWORD = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SYNC = 3'd1,
		PH_KW1  = 3'd2,
		PH_KW2  = 3'd3,
		PH_ECHO = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_AUTO_BAUD    = 3'd0,
		REG_EXP_KW1      = 3'd1,
		REG_EXP_KW2      = 3'd2,
		REG_MAX_ATTEMPTS = 3'd3,
		REG_SYNC_TIMEOUT = 3'd4,
		REG_BYTE_TIMEOUT = 3'd5,
		REG_BAUD_THRESH  = 3'd6,
		REG_TARGET_ADDR  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        auto_baud;
		logic [7:0]  exp_kw1;
		logic [7:0]  exp_kw2;
		logic [3:0]  max_attempts;
		logic [15:0] sync_timeout;
		logic [15:0] byte_timeout;
		logic [15:0] baud_thresh;
		logic [7:0]  target_addr;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		action_t    action;
		logic [7:0] out_byte;
		logic       baud_is_9600;
		status_t    status;
	} result_t;

endpackage

FILE: src/kshi_cfg.sv
// ----------------------------------------------------------------------------
// kshi_cfg
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module kshi_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_addr,
	input  logic [15:0]       cfg_wdata,
	output kshi_pkg::cfg_t    cfg
);
	import kshi_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_baud    <= 1'b0;
			cfg_q.exp_kw1      <= 8'hE9;
			cfg_q.exp_kw2      <= 8'h8F;
			cfg_q.max_attempts <= 4'd2;
			cfg_q.sync_timeout <= 16'd1000;
			cfg_q.byte_timeout <= 16'd500;
			cfg_q.baud_thresh  <= 16'd900;
			cfg_q.target_addr  <= 8'h33;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_AUTO_BAUD:    cfg_q.auto_baud    <= cfg_wdata[0];
				REG_EXP_KW1:      cfg_q.exp_kw1      <= cfg_wdata[7:0];
				REG_EXP_KW2:      cfg_q.exp_kw2      <= cfg_wdata[7:0];
				REG_MAX_ATTEMPTS: cfg_q.max_attempts <= cfg_wdata[3:0];
				REG_SYNC_TIMEOUT: cfg_q.sync_timeout <= cfg_wdata;
				REG_BYTE_TIMEOUT: cfg_q.byte_timeout <= cfg_wdata;
				REG_BAUD_THRESH:  cfg_q.baud_thresh  <= cfg_wdata;
				REG_TARGET_ADDR:  cfg_q.target_addr  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/kshi_fsm.sv
// ----------------------------------------------------------------------------
// kshi_fsm
// Handshake state: phase, attempt counter, timeout timer and keywords.
// Decides the result of one item and updates state when the item is taken.
// ----------------------------------------------------------------------------
module kshi_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [1:0]        opcode,
	input  logic [7:0]        rx_byte,
	input  logic [15:0]       sync_duration,
	input  kshi_pkg::cfg_t    cfg,
	output kshi_pkg::result_t res
);
	import kshi_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  attempt_q, attempt_d;
	logic [15:0] timer_q, timer_d;
	logic [7:0]  kw1_q, kw1_d;
	logic [7:0]  kw2_q, kw2_d;

	op_t     op;
	logic    active;
	logic    tick_expired;
	logic    echo_ok;
	logic    kw_ok;
	logic    can_retry;
	logic    fail;
	status_t fail_status;

	assign op           = op_t'(opcode);
	assign active       = (phase_q != PH_IDLE);
	assign tick_expired = (timer_q <= 16'd1);
	assign echo_ok      = (rx_byte == ~kw2_q);
	assign kw_ok        = (kw1_q == cfg.exp_kw1) && (kw2_q == cfg.exp_kw2);
	// max_attempts of zero behaves as one since the count is at least one here
	assign can_retry    = (attempt_q < cfg.max_attempts);

	// failures that go through the retry path
	always_comb begin
		fail        = 1'b0;
		fail_status = ST_OK;
		if (active) begin
			if (op == OP_TICK && tick_expired) begin
				fail        = 1'b1;
				fail_status = ST_TIMEOUT;
			end else if (op == OP_RX_BYTE && phase_q == PH_ECHO) begin
				if (!echo_ok) begin
					fail        = 1'b1;
					fail_status = ST_ECHO;
				end else if (!kw_ok) begin
					fail        = 1'b1;
					fail_status = ST_KEYWORD;
				end
			end
		end
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		attempt_d = attempt_q;
		timer_d   = timer_q;
		kw1_d     = kw1_q;
		kw2_d     = kw2_q;
		if (op == OP_START) begin
			attempt_d = 4'd1;
			phase_d   = PH_SYNC;
			timer_d   = cfg.sync_timeout;
		end else if (active) begin
			if (fail) begin
				if (op == OP_TICK) begin
					timer_d = '0;
				end
				if (can_retry) begin
					attempt_d = attempt_q + 4'd1;
					phase_d   = PH_SYNC;
					timer_d   = cfg.sync_timeout;
				end else begin
					phase_d = PH_IDLE;
				end
			end else if (op == OP_TICK) begin
				timer_d = timer_q - 16'd1;
			end else if (op == OP_SYNC_DUR) begin
				if (phase_q == PH_SYNC && cfg.auto_baud) begin
					phase_d = PH_KW1;
					timer_d = cfg.byte_timeout;
				end
			end else begin
				case (phase_q)
					PH_SYNC: begin
						if (!cfg.auto_baud) begin
							if (rx_byte != SYNC_BYTE) begin
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_KW1;
								timer_d = cfg.byte_timeout;
							end
						end
					end
					PH_KW1: begin
						kw1_d   = rx_byte;
						phase_d = PH_KW2;
					end
					PH_KW2: begin
						kw2_d   = rx_byte;
						phase_d = PH_ECHO;
					end
					PH_ECHO: begin
						// echo and keywords good: handshake done
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// result of the item
	always_comb begin
		res              = '0;
		res.action       = ACT_ADDR;
		res.status       = ST_OK;
		if (op == OP_START) begin
			res.valid    = 1'b1;
			res.action   = ACT_ADDR;
			res.out_byte = cfg.target_addr;
		end else if (active) begin
			if (fail) begin
				res.valid = 1'b1;
				if (can_retry) begin
					res.action   = ACT_ADDR;
					res.out_byte = cfg.target_addr;
				end else begin
					res.action = ACT_DONE;
					res.status = fail_status;
				end
			end else if (op == OP_SYNC_DUR) begin
				if (phase_q == PH_SYNC && cfg.auto_baud) begin
					res.valid        = 1'b1;
					res.action       = ACT_BAUD;
					res.baud_is_9600 = (sync_duration > cfg.baud_thresh);
				end
			end else if (op == OP_RX_BYTE) begin
				case (phase_q)
					PH_SYNC: begin
						if (!cfg.auto_baud && rx_byte != SYNC_BYTE) begin
							res.valid  = 1'b1;
							res.action = ACT_DONE;
							res.status = ST_SYNC;
						end
					end
					PH_KW2: begin
						res.valid    = 1'b1;
						res.action   = ACT_TX;
						res.out_byte = ~rx_byte;
					end
					PH_ECHO: begin
						res.valid  = 1'b1;
						res.action = ACT_DONE;
						res.status = ST_OK;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			attempt_q <= '0;
			timer_q   <= '0;
			kw1_q     <= '0;
			kw2_q     <= '0;
		end else if (go) begin
			phase_q   <= phase_d;
			attempt_q <= attempt_d;
			timer_q   <= timer_d;
			kw1_q     <= kw1_d;
			kw2_q     <= kw2_d;
		end
	end

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.valid && res.action == ACT_DONE |=> phase_q == PH_IDLE)
		else $error("finished result did not return to idle");

	a_addr_loads_sync_timer: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.valid && res.action == ACT_ADDR
		|=> phase_q == PH_SYNC && timer_q == $past(cfg.sync_timeout))
		else $error("address request did not arm the sync wait");

	a_attempt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> attempt_q != 4'd0)
		else $error("handshake running with zero attempt count");

endmodule

FILE: src/kshi_out.sv
// ----------------------------------------------------------------------------
// kshi_out
// Result register on the output stream; frees itself when the item is taken.
// ----------------------------------------------------------------------------
module kshi_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kshi_pkg::result_t res,
	output logic              ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic [1:0]        m_tuser
);
	import kshi_pkg::*;

	logic       valid_q;
	action_t    action_q;
	logic [7:0] byte_q;
	logic       baud_q;
	status_t    status_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			action_q <= res.action;
			byte_q   <= res.out_byte;
			baud_q   <= res.baud_is_9600;
			status_q <= res.status;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = action_q;
	assign m_tdata  = {4'd0, status_q, baud_q, byte_q};

endmodule

FILE: src/kline_slow_init_handshake_top.sv
// ----------------------------------------------------------------------------
// kline_slow_init_handshake_top
// Tester side of the K-line 5-baud slow init handshake.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output register is free or being taken.
// An accepted item sits in the input register, where the handshake logic
// decides its result; once the output register can take it, the state is
// updated and the result lands in the output register, where it is offered on
// the master side. The slave side stalls only when the output register holds
// a result that is not being taken.
// Items that cause no result leave nothing on the master side.
// ----------------------------------------------------------------------------
module kline_slow_init_handshake_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // rx_byte[7:0], sync_duration[23:8]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte[7:0], baud_is_9600[8], status[11:9]
	output logic [1:0]  m_tuser,  // action[1:0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import kshi_pkg::*;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [7:0]  rx_byte_s1;
	logic [15:0] sync_dur_s1;

	cfg_t    cfg;
	result_t res;
	logic    out_ready;
	logic    go;

	assign go       = valid_s1 && out_ready;
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1   <= s_tuser;
			rx_byte_s1  <= s_tdata[7:0];
			sync_dur_s1 <= s_tdata[23:8];
		end
	end

	kshi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	kshi_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.opcode        (opcode_s1),
		.rx_byte       (rx_byte_s1),
		.sync_duration (sync_dur_s1),
		.cfg           (cfg),
		.res           (res)
	);

	kshi_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go),
		.res      (res),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: tb/kline_slow_init_handshake_top_tb.sv
// ----------------------------------------------------------------------------
// kline_slow_init_handshake_top_tb
// Self-checking bench for the K-line 5-baud slow init handshake block.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a stream driver. A monitor predicts the result
// of every accepted item with a model of the init sequence and compares each
// result on the master side against the oldest pending expectation. A directed
// part covers the special paths. Random init sessions then run under several
// register settings, with random sender gaps, receiver stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module kline_slow_init_handshake_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kshi_pkg::*;

	typedef struct {
		op_t         op;
		logic [7:0]  rx;
		logic [15:0] dur;
	} kline_item_t;

	typedef struct {
		action_t    action;
		logic [7:0] out_byte;
		logic       baud_is_9600;
		status_t    status;
	} init_event_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	kline_slow_init_handshake_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// register shadow and handshake state of the predictor
	cfg_t cfg_shadow = '{auto_baud: 1'b0, exp_kw1: 8'hE9, exp_kw2: 8'h8F,
		max_attempts: 4'd2, sync_timeout: 16'd1000, byte_timeout: 16'd500,
		baud_thresh: 16'd900, target_addr: 8'h33};
	phase_t      kl_phase = PH_IDLE;
	logic [3:0]  kl_attempts = '0;
	logic [15:0] kl_timer = '0;
	logic [7:0]  kl_kw1 = '0;
	logic [7:0]  kl_kw2 = '0;

	kline_item_t pending_items[$];
	init_event_t expected_results[$];
	kline_item_t next_item;
	int          total_items = 0;
	int          mismatches = 0;

	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	bit sender_gaps = 1'b0;
	bit receiver_stalls = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_grants = 0;
	int hold_served = 0;

	function automatic init_event_t make_event(action_t a, logic [7:0] b, logic baud,
			status_t st);
		init_event_t ev;
		ev.action = a;
		ev.out_byte = b;
		ev.baud_is_9600 = baud;
		ev.status = st;
		return ev;
	endfunction

	function automatic init_event_t restart_attempt();
		kl_phase = PH_SYNC;
		kl_timer = cfg_shadow.sync_timeout;
		return make_event(ACT_ADDR, cfg_shadow.target_addr, 1'b0, ST_OK);
	endfunction

	function automatic init_event_t conclude(status_t st);
		kl_phase = PH_IDLE;
		return make_event(ACT_DONE, 8'h00, 1'b0, st);
	endfunction

	function automatic init_event_t retry_or_conclude(status_t st);
		if (kl_attempts >= cfg_shadow.max_attempts)
			return conclude(st);
		kl_attempts = kl_attempts + 4'd1;
		return restart_attempt();
	endfunction

	task automatic predict_init_step(input op_t op, input logic [7:0] rx,
			input logic [15:0] dur, output bit fired, output init_event_t ev);
		fired = 1'b1;
		ev = make_event(ACT_ADDR, 8'h00, 1'b0, ST_OK);
		if (op == OP_START) begin
			kl_attempts = 4'd1;
			ev = restart_attempt();
		end else if (kl_phase == PH_IDLE) begin
			fired = 1'b0;
		end else if (op == OP_TICK) begin
			if (kl_timer <= 16'd1) begin
				kl_timer = '0;
				ev = retry_or_conclude(ST_TIMEOUT);
			end else begin
				kl_timer = kl_timer - 16'd1;
				fired = 1'b0;
			end
		end else if (op == OP_SYNC_DUR) begin
			if (kl_phase != PH_SYNC || !cfg_shadow.auto_baud) begin
				fired = 1'b0;
			end else begin
				kl_phase = PH_KW1;
				kl_timer = cfg_shadow.byte_timeout;
				ev = make_event(ACT_BAUD, 8'h00, dur > cfg_shadow.baud_thresh, ST_OK);
			end
		end else begin
			case (kl_phase)
				PH_SYNC: begin
					if (cfg_shadow.auto_baud) begin
						fired = 1'b0;
					end else if (rx != SYNC_BYTE) begin
						ev = conclude(ST_SYNC);
					end else begin
						kl_phase = PH_KW1;
						kl_timer = cfg_shadow.byte_timeout;
						fired = 1'b0;
					end
				end
				PH_KW1: begin
					kl_kw1 = rx;
					kl_phase = PH_KW2;
					fired = 1'b0;
				end
				PH_KW2: begin
					kl_kw2 = rx;
					kl_phase = PH_ECHO;
					ev = make_event(ACT_TX, ~rx, 1'b0, ST_OK);
				end
				PH_ECHO: begin
					if (rx != ~kl_kw2)
						ev = retry_or_conclude(ST_ECHO);
					else if (kl_kw1 != cfg_shadow.exp_kw1 || kl_kw2 != cfg_shadow.exp_kw2)
						ev = retry_or_conclude(ST_KEYWORD);
					else
						ev = conclude(ST_OK);
				end
				default: begin
					kl_phase = PH_IDLE;
					fired = 1'b0;
				end
			endcase
		end
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// sampling, prediction and result checking
	always @(posedge clk or negedge arst_n) begin
		bit          fired;
		init_event_t ev;
		init_event_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				predict_init_step(op_t'(s_tuser), s_tdata[7:0], s_tdata[23:8], fired, ev);
				if (fired)
					expected_results.push_back(ev);
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got action %0h data %0h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("action", 16'(want.action), 16'(m_tuser));
					check_field("out_byte", 16'(want.out_byte), 16'(m_tdata[7:0]));
					check_field("baud_is_9600", 16'(want.baud_is_9600), 16'(m_tdata[8]));
					check_field("status", 16'(want.status), 16'(m_tdata[11:9]));
					check_field("padding", 16'h0, 16'(m_tdata[15:12]));
				end
			end
		end
	end

	// sender: holds an item until taken, then waits its drawn gap
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else if (s_tvalid && !in_taken) begin
			// still waiting for the block to take the item
		end else if (gap_left > 0) begin
			s_tvalid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_items.size() != 0) begin
			next_item = pending_items.pop_front();
			s_tuser <= next_item.op;
			s_tdata <= {next_item.dur, next_item.rx};
			s_tvalid <= 1'b1;
			gap_left <= sender_gaps ? $urandom_range(0, 13) : 0;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver: random stall after each result, plus long hold-offs on request
	always @(negedge clk) begin
		int d;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (hold_served != hold_grants) begin
			hold_served <= hold_grants;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (out_taken) begin
			d = receiver_stalls ? $urandom_range(0, 13) : 0;
			stall_left <= d;
			m_tready <= (d == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_item(op_t op, logic [7:0] rx, logic [15:0] dur);
		kline_item_t it;
		it.op = op;
		it.rx = rx;
		it.dur = dur;
		pending_items.push_back(it);
		total_items++;
	endtask

	task automatic push_ticks(int n);
		repeat (n) push_item(OP_TICK, 8'($urandom), 16'($urandom));
	endtask

	// durations either anywhere or right around the threshold
	function automatic logic [15:0] pick_duration();
		if ($urandom_range(0, 1))
			return 16'($urandom);
		return cfg_shadow.baud_thresh + 16'($urandom_range(0, 2)) - 16'd1;
	endfunction

	// an occasional stray item, then one start followed by mostly well-formed attempts with random faults
	task automatic push_session();
		int         tries;
		logic [7:0] kw2;
		tries = $urandom_range(1, 3);
		if ($urandom_range(0, 9) == 0)
			push_item(op_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
		push_item(OP_START, 8'($urandom), 16'($urandom));
		repeat (tries) begin
			push_ticks($urandom_range(0, 3));
			if (cfg_shadow.auto_baud) begin
				if ($urandom_range(0, 7) == 0)
					push_item(OP_RX_BYTE, SYNC_BYTE, 16'($urandom));
				push_item(OP_SYNC_DUR, 8'($urandom), pick_duration());
			end else begin
				if ($urandom_range(0, 9) == 0)
					push_item(OP_SYNC_DUR, 8'($urandom), 16'($urandom));
				push_item(OP_RX_BYTE, ($urandom_range(0, 11) == 0) ? 8'($urandom) : SYNC_BYTE,
					16'($urandom));
			end
			push_ticks($urandom_range(0, 2));
			push_item(OP_RX_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom)
				: cfg_shadow.exp_kw1, 16'($urandom));
			push_ticks($urandom_range(0, 2));
			kw2 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : cfg_shadow.exp_kw2;
			push_item(OP_RX_BYTE, kw2, 16'($urandom));
			push_ticks($urandom_range(0, 2));
			push_item(OP_RX_BYTE, ($urandom_range(0, 4) == 0) ? 8'($urandom) : ~kw2,
				16'($urandom));
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_AUTO_BAUD:    cfg_shadow.auto_baud = val[0];
			REG_EXP_KW1:      cfg_shadow.exp_kw1 = val[7:0];
			REG_EXP_KW2:      cfg_shadow.exp_kw2 = val[7:0];
			REG_MAX_ATTEMPTS: cfg_shadow.max_attempts = val[3:0];
			REG_SYNC_TIMEOUT: cfg_shadow.sync_timeout = val;
			REG_BYTE_TIMEOUT: cfg_shadow.byte_timeout = val;
			REG_BAUD_THRESH:  cfg_shadow.baud_thresh = val;
			REG_TARGET_ADDR:  cfg_shadow.target_addr = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic auto_baud, logic [7:0] kw1, logic [7:0] kw2,
			logic [3:0] attempts, logic [15:0] sync_to, logic [15:0] byte_to,
			logic [15:0] thresh, logic [7:0] addr);
		write_reg(REG_AUTO_BAUD, 16'(auto_baud));
		write_reg(REG_EXP_KW1, 16'(kw1));
		write_reg(REG_EXP_KW2, 16'(kw2));
		write_reg(REG_MAX_ATTEMPTS, 16'(attempts));
		write_reg(REG_SYNC_TIMEOUT, sync_to);
		write_reg(REG_BYTE_TIMEOUT, byte_to);
		write_reg(REG_BAUD_THRESH, thresh);
		write_reg(REG_TARGET_ADDR, 16'(addr));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// block is idle once every item is taken and every result seen; items
	// without a result may still sit in the pipeline, so let it settle before moving on
	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_setting(int which);
		case (which)
			0: write_all(1'b0, 8'h00, 8'h00, 4'd1, 16'd1, 16'd1, 16'h0000, 8'h00);
			1: write_all(1'b1, 8'hFF, 8'hFF, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
			2: write_all(1'b1, 8'hE9, 8'h8F, 4'd3, 16'd6, 16'd4, 16'd900, 8'h33);
			// zero limits behave as one
			3: write_all(1'b0, 8'h08, 8'h08, 4'd0, 16'd0, 16'd0, 16'($urandom),
				8'($urandom));
			default: write_all(1'($urandom), ($urandom_range(0, 1)) ? 8'($urandom) : 8'h08,
				($urandom_range(0, 1)) ? 8'($urandom) : 8'h8F, 4'($urandom_range(1, 15)),
				($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12)),
				($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12)),
				16'($urandom), 8'($urandom));
		endcase
	endtask

	initial begin
		int setting;
		int phase_start;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: short timeouts so the timeout path is reached quickly
		write_all(1'b0, 8'hE9, 8'h8F, 4'd2, 16'd3, 16'd2, 16'd900, 8'h33);
		push_item(OP_TICK, 8'h00, 16'h0000);
		push_item(OP_RX_BYTE, 8'hAA, 16'h0000);
		push_item(OP_SYNC_DUR, 8'h00, 16'hFFFF);
		push_item(OP_START, 8'h00, 16'h0000);
		push_item(OP_SYNC_DUR, 8'hFF, 16'hFFFF);
		push_ticks(3);
		push_item(OP_RX_BYTE, SYNC_BYTE, 16'h0000);
		push_item(OP_RX_BYTE, 8'hE9, 16'h0000);
		push_item(OP_RX_BYTE, 8'h8F, 16'h0000);
		push_item(OP_RX_BYTE, 8'h00, 16'h0000);
		push_item(OP_START, 8'hFF, 16'hFFFF);
		push_item(OP_RX_BYTE, SYNC_BYTE, 16'h0000);
		push_item(OP_RX_BYTE, 8'h08, 16'h0000);
		push_item(OP_RX_BYTE, 8'hFF, 16'h0000);
		push_item(OP_RX_BYTE, 8'h00, 16'h0000);
		push_item(OP_RX_BYTE, SYNC_BYTE, 16'h0000);
		push_item(OP_RX_BYTE, 8'hE9, 16'h0000);
		push_item(OP_RX_BYTE, 8'h8F, 16'h0000);
		push_item(OP_RX_BYTE, 8'h70, 16'h0000);
		push_item(OP_START, 8'h00, 16'h0000);
		push_item(OP_RX_BYTE, 8'h54, 16'h0000);
		push_item(OP_START, 8'h00, 16'h0000);
		push_item(OP_START, 8'h00, 16'h0000);
		drain();
		write_all(1'b1, 8'hE9, 8'h8F, 4'd2, 16'd3, 16'd2, 16'd900, 8'h33);
		push_item(OP_START, 8'h00, 16'h0000);
		push_item(OP_RX_BYTE, SYNC_BYTE, 16'h0000);
		push_item(OP_SYNC_DUR, 8'h00, 16'd901);
		push_item(OP_TICK, 8'h00, 16'h0000);
		drain();

		setting = 0;
		while (total_items < 1530) begin
			apply_setting(setting);
			sender_gaps = (setting == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			receiver_stalls = (setting == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			phase_start = total_items;
			while (total_items - phase_start < 140)
				push_session();
			drain();
			if (setting == 2) begin
				// receiver holds off while starts keep coming, so the block backs up
				hold_grants++;
				repeat (20) begin
					push_item(OP_START, 8'($urandom), 16'($urandom));
					push_item(op_t'($urandom_range(1, 3)), 8'($urandom), 16'($urandom));
				end
				drain();
			end
			setting++;
		end

		drain();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
